// ===== design/prg_pkg.sv =====
// Shared package for the Pascal row generator: field widths, store depth,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
package prg_pkg;

  localparam int unsigned RowW         = 6;
  localparam int unsigned CoefW        = 64;
  localparam int unsigned RowStoreDepth = 64;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StEdge,
    StSweep,
    StEmitRd,
    StEmitLd
  } state_e;

  typedef struct packed {
    logic we;        // write the row store
    logic wsel_one;  // write data is the edge value 1, else the pair sum
    logic re;        // read the row store
    logic load_b;    // capture read data into the upper-neighbor register
    logic load_out;  // load the output register from read data
    logic out_last;  // last flag for the item being loaded
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register is empty or drains this cycle
  } status_t;

endpackage

// ===== design/prg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/prg_datapath.sv =====
// Datapath of the Pascal row generator: row store, pair adder and output register.
// Depends on prg_pkg and prg_ram.
module prg_datapath #(
  parameter int unsigned Depth = prg_pkg::RowStoreDepth,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prg_pkg::cmd_t              cmd_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [AW-1:0]              raddr_i,
  input  logic [AW-1:0]              out_pos_i,
  output prg_pkg::status_t           status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [prg_pkg::CoefW-1:0]  coefficient_o,
  output logic [prg_pkg::RowW-1:0]   position_o,
  output logic                       last_o
);

  logic [prg_pkg::CoefW-1:0] rdata;
  logic [prg_pkg::CoefW-1:0] wdata;
  logic [prg_pkg::CoefW-1:0] b_q;
  logic                      out_valid_q, out_valid_d;
  logic [prg_pkg::CoefW-1:0] coef_q;
  logic [prg_pkg::RowW-1:0]  pos_q;
  logic                      last_q;

  // Edge entries are 1; inner entries are old row[j] plus old row[j-1].
  assign wdata = cmd_i.wsel_one ? prg_pkg::CoefW'(1) : (b_q + rdata);

  prg_ram #(
    .Width (prg_pkg::CoefW),
    .Depth (Depth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (waddr_i),
    .wdata_i (wdata),
    .re_i    (cmd_i.re),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b) begin
      b_q <= rdata;
    end
    if (cmd_i.load_out) begin
      coef_q <= rdata;
      pos_q  <= prg_pkg::RowW'(out_pos_i);
      last_q <= cmd_i.out_last;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign coefficient_o     = coef_q;
  assign position_o        = pos_q;
  assign last_o            = last_q;

endmodule

// ===== design/prg_ctrl.sv =====
// Controller of the Pascal row generator: row/sweep/emit sequencing and addresses.
// Depends on prg_pkg.
module prg_ctrl #(
  parameter int unsigned Depth = prg_pkg::RowStoreDepth,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [prg_pkg::RowW-1:0] row_index_i,
  output prg_pkg::cmd_t            cmd_o,
  output logic [AW-1:0]            waddr_o,
  output logic [AW-1:0]            raddr_o,
  output logic [AW-1:0]            out_pos_o,
  input  prg_pkg::status_t         status_i
);

  localparam logic [prg_pkg::RowW:0] MaxRow = (prg_pkg::RowW + 1)'(Depth - 1);

  prg_pkg::state_e state_q, state_d;
  logic [AW-1:0]   n_q, n_d;
  logic [AW-1:0]   i_q, i_d;
  logic [AW-1:0]   j_q, j_d;
  logic [AW-1:0]   k_q, k_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prg_pkg::StIdle: begin
        if (in_valid_i) state_d = prg_pkg::StInit;
      end
      prg_pkg::StInit: begin
        state_d = (n_q == '0) ? prg_pkg::StEmitRd : prg_pkg::StEdge;
      end
      prg_pkg::StEdge: begin
        if (i_q != AW'(1)) begin
          state_d = prg_pkg::StSweep;
        end else if (i_q == n_q) begin
          state_d = prg_pkg::StEmitRd;
        end
      end
      prg_pkg::StSweep: begin
        if (j_q == '0) begin
          state_d = (i_q == n_q) ? prg_pkg::StEmitRd : prg_pkg::StEdge;
        end
      end
      prg_pkg::StEmitRd: begin
        if (status_i.out_free) state_d = prg_pkg::StEmitLd;
      end
      prg_pkg::StEmitLd: begin
        state_d = (k_q == n_q) ? prg_pkg::StIdle : prg_pkg::StEmitRd;
      end
      default: state_d = prg_pkg::StIdle;
    endcase
  end

  // Outputs and counter updates.
  always_comb begin
    cmd_o      = '0;
    waddr_o    = '0;
    raddr_o    = '0;
    in_ready_o = 1'b0;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    unique case (state_q)
      prg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if ({1'b0, row_index_i} > MaxRow) begin
            n_d = AW'(Depth - 1);
          end else begin
            n_d = row_index_i[AW-1:0];
          end
        end
      end
      prg_pkg::StInit: begin
        cmd_o.we       = 1'b1;
        cmd_o.wsel_one = 1'b1;
        i_d            = AW'(1);
        k_d            = '0;
      end
      prg_pkg::StEdge: begin
        cmd_o.we       = 1'b1;
        cmd_o.wsel_one = 1'b1;
        waddr_o        = i_q;
        if (i_q != AW'(1)) begin
          cmd_o.re = 1'b1;
          raddr_o  = i_q - AW'(1);
          j_d      = i_q - AW'(1);
        end else if (i_q != n_q) begin
          i_d = i_q + AW'(1);
        end
      end
      prg_pkg::StSweep: begin
        // Read data holds old row[j]; the first read only primes the neighbor.
        cmd_o.load_b = 1'b1;
        if (j_q != i_q - AW'(1)) begin
          cmd_o.we = 1'b1;
          waddr_o  = j_q + AW'(1);
        end
        if (j_q != '0) begin
          cmd_o.re = 1'b1;
          raddr_o  = j_q - AW'(1);
          j_d      = j_q - AW'(1);
        end else if (i_q != n_q) begin
          i_d = i_q + AW'(1);
        end
      end
      prg_pkg::StEmitRd: begin
        if (status_i.out_free) begin
          cmd_o.re = 1'b1;
          raddr_o  = k_q;
        end
      end
      prg_pkg::StEmitLd: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_last = (k_q == n_q);
        if (k_q != n_q) k_d = k_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_pos_o = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prg_pkg::StIdle;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  a_sweep_below_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prg_pkg::StSweep |-> (j_q < i_q && i_q <= n_q))
    else $error("sweep pointer outside the row being built");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.we && cmd_o.re) |-> waddr_o != raddr_o)
    else $error("row store read and write hit the same entry");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> $past(state_q == prg_pkg::StEmitRd && status_i.out_free))
    else $error("output loaded without a granted read");

  a_emit_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prg_pkg::StEmitRd || state_q == prg_pkg::StEmitLd) |-> k_q <= n_q)
    else $error("emit position beyond row end");

endmodule

// ===== design/pascal_row_generator_core.sv =====
// Top level of the Pascal row generator: controller, datapath and row store.
// Depends on prg_pkg, prg_ctrl, prg_datapath and prg_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / row_index_i): one item is a row
//   index n. Indexes beyond ROW_STORE_DEPTH-1 are clamped to that row.
//   Output channel (out_valid_o / out_ready_i): n+1 items per request,
//   coefficient_o = C(n,k), position_o = k, for k = 0..n; last_o marks k = n.
//   Timing: the row is built in place in a single-port-read row store, one
//   pair addition per cycle, with read data registered. After the init write,
//   row 1 needs only its edge write, and each later row i an edge write and
//   then a sweep of i reads; per coefficient, emission then does a store
//   read and then an output load. The store's single read port sets the build rate.
//   One request is worked at a time; a new index is accepted as soon as the
//   final coefficient is loaded, even while it still waits in the output
//   register.
//   Reset: asynchronous, active low; control returns to idle and the output
//   register empties. The row store is not cleared: every entry is written
//   before it is read within a request.
//   Stalls: when out_ready_i is low the output register holds its item and
//   emission pauses until it drains.
module pascal_row_generator_core #(
  parameter int unsigned ROW_STORE_DEPTH = prg_pkg::RowStoreDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [prg_pkg::RowW-1:0]  row_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [prg_pkg::CoefW-1:0] coefficient_o,
  output logic [prg_pkg::RowW-1:0]  position_o,
  output logic                      last_o
);

  localparam int unsigned AW = $clog2(ROW_STORE_DEPTH);

  // Command and status bundle between sequencer and datapath.
  prg_pkg::cmd_t    cmd;
  prg_pkg::status_t status;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    out_pos;

  // Sequencer: accept, edge writes, in-place sweeps, then ordered readout.
  prg_ctrl #(
    .Depth (ROW_STORE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .row_index_i (row_index_i),
    .cmd_o       (cmd),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .out_pos_o   (out_pos),
    .status_i    (status)
  );

  // Datapath: row store, 64-bit pair adder, output register.
  prg_datapath #(
    .Depth (ROW_STORE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .waddr_i       (waddr),
    .raddr_i       (raddr),
    .out_pos_i     (out_pos),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .position_o    (position_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/sv/pascal_row_generator_core_test.sv =====
// Self-checking testbench for pascal_row_generator_core: drives row indexes,
// predicts every binomial coefficient by in-place row building, checks each output item.
// Depends on prg_pkg and the pascal_row_generator_core RTL.
`timescale 1ns / 100ps

module pascal_row_generator_core_test;

  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned IdlePercent   = 32;
  localparam int unsigned HoldoffCycles = 2500;    // longer than a full row-63 build
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned CycleLimit    = 3000000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned CalmFirstRow  = 150;     // no idling on either side in this window
  localparam int unsigned CalmLastRow   = 200;
  localparam int unsigned HoldoffAtRow  = 40;

  typedef struct {
    logic [prg_pkg::CoefW-1:0] coef;
    logic [prg_pkg::RowW-1:0]  pos;
    logic                      last;
  } coef_item_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [prg_pkg::RowW-1:0]  row_index_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [prg_pkg::CoefW-1:0] coefficient_o;
  logic [prg_pkg::RowW-1:0]  position_o;
  logic                      last_o;

  logic [prg_pkg::RowW-1:0]  pending_rows[$];
  coef_item_t                coef_expected[$];
  logic [prg_pkg::CoefW-1:0] binom_scratch[prg_pkg::RowStoreDepth];

  bit          row_offered   = 1'b0;
  bit          holdoff_done  = 1'b0;
  int unsigned holdoff_left  = 0;
  int unsigned rows_accepted = 0;
  int unsigned coefs_checked = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_count   = 0;
  logic        calm;

  assign calm = (rows_accepted >= CalmFirstRow) && (rows_accepted < CalmLastRow);

  pascal_row_generator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .row_index_i  (row_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coefficient_o(coefficient_o),
    .position_o   (position_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Build row n in place from row 0, then queue its n+1 coefficients.
  // Clamp n to the store depth, as the block does for oversized rows.
  function automatic void build_expected_row(logic [prg_pkg::RowW-1:0] row_idx);
    int         n;
    coef_item_t entry;
    n = int'(row_idx);
    if (n > int'(prg_pkg::RowStoreDepth) - 1) n = int'(prg_pkg::RowStoreDepth) - 1;
    binom_scratch[0] = prg_pkg::CoefW'(1);
    for (int i = 1; i <= n; i++) begin
      binom_scratch[i] = prg_pkg::CoefW'(1);
      for (int j = i - 1; j >= 1; j--) begin
        binom_scratch[j] = binom_scratch[j] + binom_scratch[j - 1];
      end
    end
    for (int k = 0; k <= n; k++) begin
      entry.coef = binom_scratch[k];
      entry.pos  = prg_pkg::RowW'(k);
      entry.last = (k == n);
      coef_expected.push_back(entry);
    end
  endfunction

  // Favor short rows: long ones take far longer, as the build grows with the square of n.
  task automatic push_random_rows(int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pending_rows.push_back(prg_pkg::RowW'($urandom_range(15)));
      end else if (pick < 90) begin
        pending_rows.push_back(prg_pkg::RowW'($urandom_range(47, 16)));
      end else begin
        pending_rows.push_back(prg_pkg::RowW'($urandom_range(63, 48)));
      end
    end
  endtask

  // Sender: offer the next row index at the falling edge, hold it until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!row_offered) begin
      if (pending_rows.size() > 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        row_index_i <= pending_rows.pop_front();
        in_valid_i  <= 1'b1;
        row_offered = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up
  // until it refuses new row indexes.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_ready_i <= 1'b0;
      holdoff_left--;
    end else if (!holdoff_done && rows_accepted >= HoldoffAtRow) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Input monitor: predict the row for every accepted index.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      build_expected_row(row_index_i);
      rows_accepted++;
      row_offered = 1'b0;
    end
  end

  // Output monitor: compare each accepted coefficient with the oldest prediction.
  always @(posedge clk_i) begin
    coef_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      coefs_checked++;
      if (coef_expected.size() == 0) begin
        if (mismatch_cnt < MaxReports)
          $display("%0t: unexpected item: coef=%0d pos=%0d last=%0b",
                   $realtime, coefficient_o, position_o, last_o);
        mismatch_cnt++;
      end else begin
        want = coef_expected.pop_front();
        if (coefficient_o !== want.coef || position_o !== want.pos ||
            last_o !== want.last) begin
          if (mismatch_cnt < MaxReports)
            $display({"%0t: mismatch: expected coef=%0d pos=%0d last=%0b, ",
                      "got coef=%0d pos=%0d last=%0b"},
                     $realtime, want.coef, want.pos, want.last,
                     coefficient_o, position_o, last_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d predictions outstanding",
               cycle_count, coef_expected.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: both edges, alternating bit patterns, neighbors of the
    // largest row, and row zero back to back with the largest one.
    pending_rows = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd63, 6'd62, 6'd0, 6'd63, 6'd21, 6'd42,
                     6'd31, 6'd32, 6'd4, 6'd5, 6'd10, 6'd1, 6'd0, 6'd15, 6'd48};
    wait (pending_rows.size() == 0 && !row_offered);
    // Pause the sender until the block has drained completely.
    wait (coef_expected.size() == 0);

    push_random_rows(125);
    wait (pending_rows.size() == 0 && !row_offered);
    wait (coef_expected.size() == 0);

    push_random_rows(125);
    wait (pending_rows.size() == 0 && !row_offered);
    wait (coef_expected.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d row requests (rows 0 to 63, incl. a long output stall)",
             rows_accepted);
    $display("and checked %0d coefficients with %0d mismatches", coefs_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && coef_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
